// ===== sv/qah_pkg.sv =====
// ----------------------------------------------------------------------------
// qah_pkg
// Widths and latencies shared by the quadrilateral area datapath.
// ----------------------------------------------------------------------------
package qah_pkg;

   localparam int COORD_W  = 16;
   localparam int DSQ_W    = 2 * COORD_W + 2;
   localparam int LEN_W    = DSQ_W / 2;
   localparam int FAC_W    = LEN_W + 1;
   localparam int PER_W    = LEN_W + 2;
   localparam int SPLIT_W  = FAC_W;
   localparam int M1_W     = PER_W + FAC_W;
   localparam int M2_W     = 2 * FAC_W;
   localparam int PART_W   = M1_W + SPLIT_W;
   localparam int PROD_W   = 2 * ((PART_W + SPLIT_W + 1) / 2);
   localparam int TERM_W   = PROD_W / 2;
   localparam int TOT_W    = TERM_W + 1;
   localparam int AREA_W   = 32;

   localparam int SIDE_LAT = 3 + LEN_W;
   localparam int TRI_LAT  = 4 + TERM_W;
   localparam int PIPE_LAT = SIDE_LAT + TRI_LAT + 1;

endpackage

// ===== sv/qah_side_lane.sv =====
// ----------------------------------------------------------------------------
// qah_side_lane
// Distance between two corners: floor(sqrt(dx*dx + dy*dy)), fully pipelined.
// ----------------------------------------------------------------------------
module qah_side_lane (
   input  logic                      clock,
   input  logic                      en,
   input  logic [qah_pkg::COORD_W-1:0] x1,
   input  logic [qah_pkg::COORD_W-1:0] y1,
   input  logic [qah_pkg::COORD_W-1:0] x2,
   input  logic [qah_pkg::COORD_W-1:0] y2,
   output logic [qah_pkg::LEN_W-1:0]   len
);
   import qah_pkg::*;

   logic [COORD_W-1:0]   dx_ff, dy_ff, dx_in, dy_in;
   logic [2*COORD_W-1:0] sqx_ff, sqy_ff;
   logic [DSQ_W-1:0]     dsq_ff;
   logic [LEN_W+1:0]     rem_ff  [LEN_W];
   logic [LEN_W-1:0]     root_ff [LEN_W];
   logic [DSQ_W-1:0]     rad_ff  [LEN_W];

   always_comb begin
      dx_in = (x1 > x2) ? x1 - x2 : x2 - x1;
      dy_in = (y1 > y2) ? y1 - y2 : y2 - y1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         sqx_ff <= dx_ff * dx_ff;
         sqy_ff <= dy_ff * dy_ff;
         dsq_ff <= DSQ_W'(sqx_ff) + DSQ_W'(sqy_ff);
      end
   end

   for (genvar k = 0; k < LEN_W; k++) begin : g_sqrt
      logic [LEN_W+1:0] rem_src, rsh, trial, rem_in;
      logic [LEN_W-1:0] root_src, root_in;
      logic [DSQ_W-1:0] rad_src;
      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = dsq_ff;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end
      always_comb begin
         rsh   = {rem_src[LEN_W-1:0], rad_src[DSQ_W-1-2*k -: 2]};
         trial = {root_src, 2'b01};
         if (rsh >= trial) begin
            rem_in  = rsh - trial;
            root_in = {root_src[LEN_W-2:0], 1'b1};
         end else begin
            rem_in  = rsh;
            root_in = {root_src[LEN_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_src;
         end
      end
   end

   assign len = root_ff[LEN_W-1];

endmodule

// ===== sv/qah_tri_lane.sv =====
// ----------------------------------------------------------------------------
// qah_tri_lane
// Heron term of one triangle: floor(sqrt((a+b+c)(b+c-a)(a+c-b)(a+b-c))).
// ----------------------------------------------------------------------------
module qah_tri_lane (
   input  logic                      clock,
   input  logic                      en,
   input  logic [qah_pkg::LEN_W-1:0]  a,
   input  logic [qah_pkg::LEN_W-1:0]  b,
   input  logic [qah_pkg::LEN_W-1:0]  c,
   output logic [qah_pkg::TERM_W-1:0] term
);
   import qah_pkg::*;

   logic [PER_W-1:0]  per_ff, per_in;
   logic [FAC_W-1:0]  f1_ff, f2_ff, f3_ff, f1_in, f2_in, f3_in;
   logic [FAC_W-1:0]  bc, ac, ab;
   logic [M1_W-1:0]   m1_ff;
   logic [M2_W-1:0]   m2_ff;
   logic [PART_W-1:0] plo_ff, phi_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [TERM_W+1:0] rem_ff  [TERM_W];
   logic [TERM_W-1:0] root_ff [TERM_W];
   logic [PROD_W-1:0] rad_ff  [TERM_W];

   always_comb begin
      bc     = FAC_W'(b) + FAC_W'(c);
      ac     = FAC_W'(a) + FAC_W'(c);
      ab     = FAC_W'(a) + FAC_W'(b);
      per_in = PER_W'(a) + PER_W'(b) + PER_W'(c);
      f1_in  = (bc > FAC_W'(a)) ? bc - FAC_W'(a) : '0;
      f2_in  = (ac > FAC_W'(b)) ? ac - FAC_W'(b) : '0;
      f3_in  = (ab > FAC_W'(c)) ? ab - FAC_W'(c) : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         per_ff  <= per_in;
         f1_ff   <= f1_in;
         f2_ff   <= f2_in;
         f3_ff   <= f3_in;
         m1_ff   <= M1_W'(per_ff) * M1_W'(f1_ff);
         m2_ff   <= M2_W'(f2_ff) * M2_W'(f3_ff);
         plo_ff  <= PART_W'(m1_ff) * PART_W'(m2_ff[SPLIT_W-1:0]);
         phi_ff  <= PART_W'(m1_ff) * PART_W'(m2_ff[M2_W-1:SPLIT_W]);
         prod_ff <= PROD_W'(plo_ff) + (PROD_W'(phi_ff) << SPLIT_W);
      end
   end

   for (genvar k = 0; k < TERM_W; k++) begin : g_sqrt
      logic [TERM_W+1:0] rem_src, rsh, trial, rem_in;
      logic [TERM_W-1:0] root_src, root_in;
      logic [PROD_W-1:0] rad_src;
      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = prod_ff;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end
      always_comb begin
         rsh   = {rem_src[TERM_W-1:0], rad_src[PROD_W-1-2*k -: 2]};
         trial = {root_src, 2'b01};
         if (rsh >= trial) begin
            rem_in  = rsh - trial;
            root_in = {root_src[TERM_W-2:0], 1'b1};
         end else begin
            rem_in  = rsh;
            root_in = {root_src[TERM_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_src;
         end
      end
   end

   assign term = root_ff[TERM_W-1];

endmodule

// ===== sv/quadrilateral_area_heron_core.sv =====
// ----------------------------------------------------------------------------
// quadrilateral_area_heron_core
// Takes one word of four Q12.4 corners per cycle while req_tready is high and
// returns the area in Q24.8 pixel^2, split along the corner1-corner3 diagonal
// and summed from two Heron terms. Five side lanes and two triangle lanes run
// side by side, each a fully pipelined bit-per-stage square root, so one word
// enters per clock unless the pipe stalls. The result passes through 63
// register stages: 3 difference and square stages, the 17-stage length root,
// 4 Heron product stages, the 37-stage Heron root, the merge and the output
// register. An output skid stage lets the pipe keep taking words while one
// result waits; once the skid holds a second, req_tready drops and the pipe
// stalls. Areas above 32 bits are clipped to all ones, flagged in rsp_tuser.
// ----------------------------------------------------------------------------
module quadrilateral_area_heron_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
   // corner3_x, corner3_y
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // area
   output logic [31:0]  rsp_tdata,
   // saturated
   output logic         rsp_tuser
);
   import qah_pkg::*;

   logic                en;
   logic [COORD_W-1:0]  cx [4];
   logic [COORD_W-1:0]  cy [4];
   logic [LEN_W-1:0]    a1, b1, d13, a2, b2;
   logic [TERM_W-1:0]   t1, t2;
   logic [TOT_W-1:0]    tot;
   logic [AREA_W-1:0]   area_ff;
   logic                sat_ff;
   logic [PIPE_LAT-1:0] vld_ff;
   logic [AREA_W-1:0]   out_area_ff, skid_area_ff;
   logic                out_sat_ff, skid_sat_ff;
   logic                out_v_ff, skid_v_ff;
   logic                push;

   for (genvar i = 0; i < 4; i++) begin : g_unpack
      assign cx[i] = req_tdata[2*i*COORD_W +: COORD_W];
      assign cy[i] = req_tdata[(2*i+1)*COORD_W +: COORD_W];
   end

   assign en         = !skid_v_ff;
   assign req_tready = en;
   assign push       = en && vld_ff[PIPE_LAT-1];

   qah_side_lane u_s01 (.clock, .en, .x1(cx[0]), .y1(cy[0]), .x2(cx[1]), .y2(cy[1]),
                        .len(a1));
   qah_side_lane u_s03 (.clock, .en, .x1(cx[0]), .y1(cy[0]), .x2(cx[3]), .y2(cy[3]),
                        .len(b1));
   qah_side_lane u_s13 (.clock, .en, .x1(cx[1]), .y1(cy[1]), .x2(cx[3]), .y2(cy[3]),
                        .len(d13));
   qah_side_lane u_s12 (.clock, .en, .x1(cx[1]), .y1(cy[1]), .x2(cx[2]), .y2(cy[2]),
                        .len(a2));
   qah_side_lane u_s23 (.clock, .en, .x1(cx[2]), .y1(cy[2]), .x2(cx[3]), .y2(cy[3]),
                        .len(b2));

   qah_tri_lane u_t1 (.clock, .en, .a(a1), .b(b1), .c(d13), .term(t1));
   qah_tri_lane u_t2 (.clock, .en, .a(a2), .b(b2), .c(d13), .term(t2));

   assign tot = TOT_W'(t1) + TOT_W'(t2);

   // merge: quarter the sum and clip
   always_ff @(posedge clock) begin
      if (en) begin
         if (|tot[TOT_W-1:AREA_W+2]) begin
            area_ff <= '1;
            sat_ff  <= 1'b1;
         end else begin
            area_ff <= tot[AREA_W+1:2];
            sat_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (rsp_tready || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tready || !out_v_ff) begin
         if (skid_v_ff) begin
            out_area_ff <= skid_area_ff;
            out_sat_ff  <= skid_sat_ff;
         end else begin
            out_area_ff <= area_ff;
            out_sat_ff  <= sat_ff;
         end
      end else if (push) begin
         skid_area_ff <= area_ff;
         skid_sat_ff  <= sat_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_area_ff;
   assign rsp_tuser  = out_sat_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff) else $error("skid word without output word");

   a_clip_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '1)) else $error("clip flag without full area");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(vld_ff)) else $error("pipe moved while frozen");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives corner words into the quadrilateral area core with random gaps and
// back-pressure, predicts each area from a bit-exact fixed-point model of
// the diagonal split and the two Heron terms, and compares every result word.
// ----------------------------------------------------------------------------
module tb;
   import qah_pkg::*;

   localparam int MAX_CYCLES = 2000000;

   typedef struct packed {
      logic [31:0] area;
      logic        sat;
   } area_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         rsp_tuser;

   area_type area_q[$];
   int    n_err = 0;
   int    n_sent = 0;
   int    n_got = 0;
   int    n_sat = 0;
   int    cycles = 0;

   quadrilateral_area_heron_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] isqrt(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  cand;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         cand = r | (64'd1 << k);
         if ({64'd0, cand} * {64'd0, cand} <= v) r = cand;
      end
      return r;
   endfunction

   function automatic logic [63:0] edge_len(logic [15:0] x1, logic [15:0] y1,
                                            logic [15:0] x2, logic [15:0] y2);
      logic [63:0] dx;
      logic [63:0] dy;
      dx = (x1 > x2) ? 64'(x1 - x2) : 64'(x2 - x1);
      dy = (y1 > y2) ? 64'(y1 - y2) : 64'(y2 - y1);
      return isqrt({64'd0, dx * dx + dy * dy});
   endfunction

   function automatic logic [63:0] clamp_diff(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] c);
      return (a + b > c) ? a + b - c : 64'd0;
   endfunction

   function automatic logic [63:0] heron_root(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] c);
      logic [127:0] p;
      p = 128'(a) + 128'(b) + 128'(c);
      p = p * 128'(clamp_diff(b, c, a));
      p = p * 128'(clamp_diff(a, c, b));
      p = p * 128'(clamp_diff(a, b, c));
      return isqrt(p);
   endfunction

   function automatic area_type quad_area(logic [127:0] w);
      logic [15:0] c[8];
      logic [63:0] a1, b1, d13, a2, b2;
      logic [64:0] sum;
      area_type r;
      for (int i = 0; i < 8; i++) c[i] = w[16*i +: 16];
      a1  = edge_len(c[0], c[1], c[2], c[3]);
      b1  = edge_len(c[0], c[1], c[6], c[7]);
      d13 = edge_len(c[2], c[3], c[6], c[7]);
      a2  = edge_len(c[2], c[3], c[4], c[5]);
      b2  = edge_len(c[4], c[5], c[6], c[7]);
      sum = ({1'b0, heron_root(a1, b1, d13)} + {1'b0, heron_root(a2, b2, d13)}) >> 2;
      if (sum > 65'hFFFF_FFFF) begin
         r.area = 32'hFFFF_FFFF;
         r.sat  = 1'b1;
      end else begin
         r.area = sum[31:0];
         r.sat  = 1'b0;
      end
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      n_err++;
      $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_got);
   endtask

   // result side: random stall, then check
   initial begin
      area_type e;
      int    gap;
      @(posedge clock);
      while (1) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (area_q.size() == 0) begin
            report("unexpected", rsp_tdata, 32'd0);
         end else begin
            e = area_q.pop_front();
            if (rsp_tdata !== e.area) report("area", rsp_tdata, e.area);
            if (rsp_tuser !== e.sat) report("saturated", 32'(rsp_tuser), 32'(e.sat));
         end
         n_got++;
      end
   end

   bit no_gaps = 0;

   task automatic send_corners(logic [127:0] w);
      int gap;
      area_type e;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      e = quad_area(w);
      if (e.sat) n_sat++;
      area_q.insert(area_q.size(), e);
      n_sent++;
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [127:0] pack8(int c0x, int c0y, int c1x, int c1y,
                                          int c2x, int c2y, int c3x, int c3y);
      return {c3y[15:0], c3x[15:0], c2y[15:0], c2x[15:0],
              c1y[15:0], c1x[15:0], c0y[15:0], c0x[15:0]};
   endfunction

   task automatic test_directed();
      send_corners('0);
      send_corners({128{1'b1}});
      send_corners(pack8(0, 0, 65535, 0, 65535, 65535, 0, 65535));
      send_corners(pack8(0, 65535, 65535, 65535, 65535, 0, 0, 0));
      send_corners(pack8(160, 160, 320, 160, 320, 320, 160, 320));
      send_corners(pack8(0, 0, 16, 0, 16, 16, 0, 16));
      send_corners(pack8(0, 0, 100, 100, 200, 200, 300, 300));
      send_corners(pack8(0, 0, 65535, 65535, 0, 0, 65535, 65535));
      send_corners(pack8(0, 0, 65535, 65535, 65535, 0, 0, 65535));
      send_corners(pack8(5000, 5000, 9000, 5200, 6000, 5100, 4000, 9000));
      send_corners(pack8(32768, 0, 65535, 32768, 32768, 65535, 0, 32768));
      send_corners(pack8(1, 1, 1, 1, 1, 1, 1, 1));
      send_corners(pack8(0, 0, 65535, 0, 0, 0, 0, 65535));
      send_corners(128'h5555_AAAA_5555_AAAA_5555_AAAA_5555_AAAA);
      send_corners(128'hAAAA_5555_AAAA_5555_AAAA_5555_AAAA_5555);
   endtask

   function automatic logic [127:0] rand_quad();
      logic [127:0] w;
      int cx, cy, r;
      case ($urandom_range(0, 3))
         0: for (int i = 0; i < 4; i++) w[32*i +: 32] = $urandom;
         1: begin
            cx = $urandom_range(0, 65535);
            cy = $urandom_range(0, 65535);
            r  = $urandom_range(1, 4000);
            for (int i = 0; i < 8; i++)
               w[16*i +: 16] = 16'(((i % 2) ? cy : cx) + int'($urandom_range(0, r)));
         end
         2: begin
            for (int i = 0; i < 8; i++)
               w[16*i +: 16] = $urandom_range(0, 1) ? 16'($urandom_range(60000, 65535))
                                                   : 16'($urandom_range(0, 5535));
         end
         default: begin
            cx = $urandom_range(0, 60000);
            cy = $urandom_range(0, 60000);
            r  = $urandom_range(0, 255);
            w  = pack8(cx, cy, cx + r, cy, cx + r, cy + r, cx, cy + r);
         end
      endcase
      return w;
   endfunction

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         no_gaps = (i % 100) >= 80;
         send_corners(rand_quad());
      end
      no_gaps = 0;
   endtask

   task automatic drain();
      idle_sender();
      while (area_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 20) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      test_random(300);
      drain();
      test_random(300);
      drain();
      $display("sent %0d corner words, checked %0d areas, %0d saturated",
               n_sent, n_got, n_sat);
      if (n_err == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/qah_pkg.sv
sv/qah_side_lane.sv
sv/qah_tri_lane.sv
sv/quadrilateral_area_heron_core.sv
verif/tb.sv
